/* hw/rtl/tpte_pkg.sv */
// ----------------------------------------------------------------------------
// tpte_pkg
// Shared types and constants for the tape pulse to tap encoder.
// ----------------------------------------------------------------------------
package tpte_pkg;

   localparam int DELTA_W = 33;
   localparam int PROD_W  = 54;
   localparam int DVD_W   = 55;
   localparam int DVS_W   = 28;
   localparam int LEN_W   = 36;

   localparam logic [LEN_W-1:0] DATA_LIMIT = 36'd2040;
   localparam logic [LEN_W-1:0] PART_MAX   = 36'h000ffffff;
   localparam logic [LEN_W-1:0] PART_HALF  = 36'h00055_5555;
   localparam logic [LEN_W-1:0] PART_BIG   = 36'h0007fffff;
   localparam logic [19:0]      MHZ_DIV    = 20'd1000000;

   localparam logic [31:0] WORD_HALF = 32'h55555500;
   localparam logic [31:0] WORD_BIG  = 32'h7fffff00;
   localparam logic [31:0] WORD_FULL = 32'hffffff00;

   localparam logic [2:0] CNT_BYTE = 3'd1;
   localparam logic [2:0] CNT_WORD = 3'd4;

   localparam logic [1:0] CSR_VERSION   = 2'd0;
   localparam logic [1:0] CSR_FREQ      = 2'd1;
   localparam logic [1:0] CSR_PRECISION = 2'd2;

   localparam logic [1:0] VER_0 = 2'd0;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV1,
      ST_DIV2,
      ST_CLASSIFY,
      ST_SCAN,
      ST_PRE,
      ST_EMIT_V0,
      ST_EMIT_W
   } back_state_type;

   typedef struct packed {
      logic [1:0]  version;
      logic [20:0] freq;
      logic [7:0]  precision;
   } cfg_type;

endpackage

/* hw/rtl/tpte_queue.sv */
// ----------------------------------------------------------------------------
// tpte_queue
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module tpte_queue #(
   parameter int WIDTH = 33
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0]       cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ pop;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign pop_data = mem_ff[rd_ff];
   assign full     = cnt_ff == 2'd2;
   assign empty    = cnt_ff == 2'd0;

endmodule

/* hw/rtl/tpte_front.sv */
// ----------------------------------------------------------------------------
// tpte_front
// Drops the leading half-wave, pairs half-waves in versions 0 and 1, queues wave durations.
// ----------------------------------------------------------------------------
module tpte_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [31:0]                   req_halfwave_ticks,
   input  logic [1:0]                    version,
   input  logic                          queue_full,
   output logic                          push,
   output logic [tpte_pkg::DELTA_W-1:0]  push_delta
);

   logic        first_ff, first_in;
   logic        half_ff, half_in;
   logic [31:0] held_ff, held_in;
   logic        accept, paired;

   always_comb begin
      req_ready  = !queue_full;
      accept     = req_valid && req_ready;
      paired     = !version[1];
      first_in   = first_ff;
      half_in    = half_ff;
      held_in    = held_ff;
      push       = 1'b0;
      push_delta = paired ? {1'b0, held_ff} + {1'b0, req_halfwave_ticks}
                          : {1'b0, req_halfwave_ticks};
      if (accept) begin
         if (!first_ff) begin
            first_in = 1'b1;
         end else if (paired && !half_ff) begin
            held_in = req_halfwave_ticks;
            half_in = 1'b1;
         end else begin
            half_in = 1'b0;
            push    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b0;
         half_ff  <= 1'b0;
         held_ff  <= 32'd0;
      end else begin
         first_ff <= first_in;
         half_ff  <= half_in;
         held_ff  <= held_in;
      end
   end

endmodule

/* hw/rtl/tpte_div.sv */
// ----------------------------------------------------------------------------
// tpte_div
// Serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpte_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [tpte_pkg::DVD_W-1:0]  dividend,
   input  logic [tpte_pkg::DVS_W-1:0]  divisor,
   output logic                        done,
   output logic [tpte_pkg::DVD_W-1:0]  quotient
);

   localparam int DW = tpte_pkg::DVD_W;
   localparam int SW = tpte_pkg::DVS_W;

   logic          busy_ff, busy_in, done_ff, done_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [DW-1:0] quo_ff, quo_in;
   logic [SW-1:0] rem_ff, rem_in;
   logic [SW-1:0] dvs_ff, dvs_in;
   logic [SW:0]   trial;
   logic          ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DW-1]};
      ge      = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 6'(DW - 1);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         rem_in = ge ? SW'(trial - {1'b0, dvs_ff}) : trial[SW-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* hw/rtl/tpte_back.sv */
// ----------------------------------------------------------------------------
// tpte_back
// Scales a wave to machine cycles and emits data bytes or pause words.
// ----------------------------------------------------------------------------
module tpte_back #(
   parameter int MAX_PAUSE_WORDS    = 60,
   parameter int MAX_PAUSE_BYTES_V0 = 62
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tpte_pkg::cfg_type             cfg,
   input  logic                          queue_empty,
   input  logic [tpte_pkg::DELTA_W-1:0]  queue_delta,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [31:0]                   rsp_data_word,
   output logic [2:0]                    rsp_byte_count,
   output logic                          rsp_last,
   output logic                          rsp_saturated
);

   localparam int LW = tpte_pkg::LEN_W;
   localparam logic [LW-1:0] CAP_V0 = LW'(MAX_PAUSE_BYTES_V0 * 2040);
   localparam logic [LW-1:0] CAP_V1 = LW'(MAX_PAUSE_WORDS * 64'h00ffffff);
   localparam logic [LW-1:0] CAP_V2 = LW'((MAX_PAUSE_WORDS - 1) * 64'h00ffffff);

   tpte_pkg::back_state_type st_ff, st_in;

   logic [tpte_pkg::DELTA_W-1:0] delta_ff, delta_in;
   logic [tpte_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [LW-1:0]                len_ff, len_in, r_ff, r_in, scan_ff, scan_in;
   logic                         sat_ff, sat_in, par_ff, par_in, half_ff, half_in;
   logic [1:0]                   pre_ff, pre_in;

   logic                         div_start, div_done;
   logic [tpte_pkg::DVD_W-1:0]   div_dvd, div_quo;
   logic [tpte_pkg::DVS_W-1:0]   div_dvs;
   logic [7:0]                   prec_eff;

   logic        out_free, out_load;
   logic [31:0] o_word;
   logic [2:0]  o_cnt;
   logic        o_last, o_sat;
   logic [LW-1:0] cap, clip;
   logic        v2;

   logic        rv_ff, rv_in;
   logic [31:0] word_ff;
   logic [2:0]  cnt_ff;
   logic        last_ff, satq_ff;

   tpte_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= tpte_pkg::ST_IDLE;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
      end
      delta_ff <= delta_in;
      prod_ff  <= prod_in;
      len_ff   <= len_in;
      r_ff     <= r_in;
      scan_ff  <= scan_in;
      sat_ff   <= sat_in;
      par_ff   <= par_in;
      half_ff  <= half_in;
      pre_ff   <= pre_in;
      if (out_load) begin
         word_ff <= o_word;
         cnt_ff  <= o_cnt;
         last_ff <= o_last;
         satq_ff <= o_sat;
      end
   end

   always_comb begin
      out_free  = !rv_ff || rsp_ready;
      v2        = cfg.version[1];
      prec_eff  = (cfg.precision == 8'd0) ? 8'd1 : cfg.precision;
      cap       = (cfg.version == tpte_pkg::VER_0) ? CAP_V0 : (v2 ? CAP_V2 : CAP_V1);
      clip      = (len_ff > cap) ? cap : len_ff;
      st_in     = st_ff;
      delta_in  = delta_ff;
      prod_in   = prod_ff;
      len_in    = len_ff;
      r_in      = r_ff;
      scan_in   = scan_ff;
      sat_in    = sat_ff;
      par_in    = par_ff;
      half_in   = half_ff;
      pre_in    = pre_ff;
      pop       = 1'b0;
      div_start = 1'b0;
      // one division by precision * 1e6, rounding term is half the divisor
      div_dvs   = tpte_pkg::DVS_W'(prec_eff) * tpte_pkg::DVS_W'(tpte_pkg::MHZ_DIV);
      div_dvd   = tpte_pkg::DVD_W'(prod_ff)
                + tpte_pkg::DVD_W'(div_dvs[tpte_pkg::DVS_W-1:1]);
      out_load  = 1'b0;
      o_word    = 32'd0;
      o_cnt     = tpte_pkg::CNT_WORD;
      o_last    = 1'b0;
      o_sat     = sat_ff;
      case (st_ff)
         tpte_pkg::ST_IDLE: begin
            if (!queue_empty) begin
               pop      = 1'b1;
               delta_in = queue_delta;
               st_in    = tpte_pkg::ST_MUL;
            end
         end
         tpte_pkg::ST_MUL: begin
            prod_in = tpte_pkg::PROD_W'(delta_ff) * tpte_pkg::PROD_W'(cfg.freq);
            st_in   = tpte_pkg::ST_DIV1;
         end
         tpte_pkg::ST_DIV1: begin
            div_start = 1'b1;
            st_in     = tpte_pkg::ST_DIV2;
         end
         tpte_pkg::ST_DIV2: begin
            if (div_done) begin
               len_in = div_quo[LW-1:0];
               st_in  = tpte_pkg::ST_CLASSIFY;
            end
         end
         tpte_pkg::ST_CLASSIFY: begin
            sat_in  = len_ff > cap;
            r_in    = clip;
            scan_in = clip;
            par_in  = 1'b0;
            if (len_ff <= tpte_pkg::DATA_LIMIT) begin
               o_word = {24'd0, 8'((len_ff + 36'd4) >> 3)};
               o_cnt  = tpte_pkg::CNT_BYTE;
               o_last = 1'b1;
               o_sat  = 1'b0;
               if (out_free) begin
                  out_load = 1'b1;
                  st_in    = tpte_pkg::ST_IDLE;
               end
            end else if (cfg.version == tpte_pkg::VER_0) begin
               st_in = tpte_pkg::ST_EMIT_V0;
            end else if (v2 && clip > tpte_pkg::PART_MAX) begin
               st_in = tpte_pkg::ST_SCAN;
            end else begin
               st_in = tpte_pkg::ST_EMIT_W;
            end
         end
         tpte_pkg::ST_SCAN: begin
            // count whole parts to learn the part parity and the remainder
            if (scan_ff > tpte_pkg::PART_MAX) begin
               scan_in = scan_ff - tpte_pkg::PART_MAX;
               par_in  = !par_ff;
            end else if (par_ff) begin
               half_in = 1'b1;
               pre_in  = 2'd2;
               st_in   = tpte_pkg::ST_PRE;
            end else if (scan_ff == tpte_pkg::PART_MAX || scan_ff < tpte_pkg::PART_BIG) begin
               half_in = 1'b0;
               pre_in  = 2'd1;
               st_in   = tpte_pkg::ST_PRE;
            end else begin
               st_in = tpte_pkg::ST_EMIT_W;
            end
         end
         tpte_pkg::ST_PRE: begin
            o_word = half_ff ? tpte_pkg::WORD_HALF : tpte_pkg::WORD_BIG;
            if (out_free) begin
               out_load = 1'b1;
               r_in     = r_ff - (half_ff ? tpte_pkg::PART_HALF : tpte_pkg::PART_BIG);
               pre_in   = pre_ff - 2'd1;
               if (pre_ff == 2'd1) begin
                  st_in = tpte_pkg::ST_EMIT_W;
               end
            end
         end
         tpte_pkg::ST_EMIT_V0: begin
            o_cnt  = tpte_pkg::CNT_BYTE;
            o_last = r_ff <= tpte_pkg::DATA_LIMIT;
            if (out_free) begin
               out_load = 1'b1;
               r_in     = r_ff - tpte_pkg::DATA_LIMIT;
               if (o_last) begin
                  st_in = tpte_pkg::ST_IDLE;
               end
            end
         end
         tpte_pkg::ST_EMIT_W: begin
            o_last = r_ff <= tpte_pkg::PART_MAX;
            o_word = o_last ? {r_ff[23:0], 8'd0} : tpte_pkg::WORD_FULL;
            if (out_free) begin
               out_load = 1'b1;
               r_in     = r_ff - tpte_pkg::PART_MAX;
               if (o_last) begin
                  st_in = tpte_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            st_in = tpte_pkg::ST_IDLE;
         end
      endcase
      rv_in = out_load || (rv_ff && !rsp_ready);
   end

   assign rsp_valid      = rv_ff;
   assign rsp_data_word  = word_ff;
   assign rsp_byte_count = cnt_ff;
   assign rsp_last       = last_ff;
   assign rsp_saturated  = satq_ff;

`ifndef SYNTHESIS
   a_byte_fits: assert property (@(posedge clock) disable iff (reset)
      rv_ff && cnt_ff == tpte_pkg::CNT_BYTE |-> word_ff[31:8] == 24'd0)
      else $error("byte result wider than a byte");
   a_word_low: assert property (@(posedge clock) disable iff (reset)
      rv_ff && cnt_ff == tpte_pkg::CNT_WORD |-> word_ff[7:0] == 8'd0)
      else $error("pause word low byte not zero");
   a_pre_left: assert property (@(posedge clock) disable iff (reset)
      st_ff == tpte_pkg::ST_PRE |-> pre_ff != 2'd0)
      else $error("prefix count ran out");
   a_word_rest: assert property (@(posedge clock) disable iff (reset)
      st_ff == tpte_pkg::ST_EMIT_W |-> r_ff != '0)
      else $error("pause emission with nothing left");
`endif

endmodule

/* hw/rtl/tape_pulse_to_tap_encoder.sv */
// a data byte result follows the request transfer through multiply, one serial
// 55-step division and classify; pause words are loaded from the emit states
// after classify, and version 2 pauses first pass a scan that counts parts
// the back takes a new wave from the queue only once it is idle again; the
// serial divider dominates; versions 0 and 1 take two half-waves per wave
// reset: synchronous, active high; registers return to version 1, 985248 hz,
// 1 mhz, and the first half-wave after reset is dropped
// ----------------------------------------------------------------------------
// tape_pulse_to_tap_encoder
// Half-wave durations in, tap data bytes and pause words out.
// ----------------------------------------------------------------------------
module tape_pulse_to_tap_encoder #(
   parameter int MAX_PAUSE_WORDS    = 60,
   parameter int MAX_PAUSE_BYTES_V0 = 62
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_halfwave_ticks,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_data_word,
   output logic [2:0]  rsp_byte_count,
   output logic        rsp_last,
   output logic        rsp_saturated
);

   tpte_pkg::cfg_type cfg_ff, cfg_in;

   logic                         push, pop, q_full, q_empty;
   logic [tpte_pkg::DELTA_W-1:0] push_delta, pop_delta;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            tpte_pkg::CSR_VERSION:   cfg_in.version   = csr_data[1:0];
            tpte_pkg::CSR_FREQ:      cfg_in.freq      = csr_data[20:0];
            tpte_pkg::CSR_PRECISION: cfg_in.precision = csr_data[7:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.version   <= 2'd1;
         cfg_ff.freq      <= 21'd985248;
         cfg_ff.precision <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tpte_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_halfwave_ticks (req_halfwave_ticks),
      .version            (cfg_ff.version),
      .queue_full         (q_full),
      .push               (push),
      .push_delta         (push_delta)
   );

   tpte_queue #(.WIDTH(tpte_pkg::DELTA_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_delta),
      .pop       (pop),
      .pop_data  (pop_delta),
      .full      (q_full),
      .empty     (q_empty)
   );

   tpte_back #(
      .MAX_PAUSE_WORDS    (MAX_PAUSE_WORDS),
      .MAX_PAUSE_BYTES_V0 (MAX_PAUSE_BYTES_V0)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .queue_empty    (q_empty),
      .queue_delta    (pop_delta),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data_word  (rsp_data_word),
      .rsp_byte_count (rsp_byte_count),
      .rsp_last       (rsp_last),
      .rsp_saturated  (rsp_saturated)
   );

endmodule

/* dv/tpte_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpte_checker
// Watches the register, request and response transfers of the tap encoder,
// predicts the tap words each half-wave produces and compares them in order.
// ----------------------------------------------------------------------------
module tpte_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [31:0] req_halfwave_ticks,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_data_word,
   input  logic [2:0]  rsp_byte_count,
   input  logic        rsp_last,
   input  logic        rsp_saturated,
   output int          fail_count,
   output int          pending_words
);

   localparam int MAX_PAUSE_WORDS_TB    = 60;
   localparam int MAX_PAUSE_BYTES_V0_TB = 62;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  cnt;
      logic        last;
      logic        sat;
   } tap_out_type;

   tap_out_type       tap_queue[$];
   tpte_pkg::cfg_type cfg;
   logic              first_seen;
   logic              have_half;
   logic [31:0]       held_ticks;

   assign pending_words = tap_queue.size();

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, want);
      fail_count++;
   endtask

   task automatic push_word(input logic [31:0] w, input logic [2:0] c, input logic s);
      tap_out_type t;
      t.word = w;
      t.cnt  = c;
      t.last = 1'b0;
      t.sat  = s;
      tap_queue.push_back(t);
   endtask

   task automatic encode_halfwave(input logic [31:0] ticks);
      logic [63:0] delta;
      logic [63:0] len;
      logic [63:0] prec;
      logic [63:0] cap;
      logic [63:0] parts;
      logic        paired;
      logic        v2;
      logic        sat;
      int          before_n;
      before_n = tap_queue.size();
      paired = (cfg.version == 2'd0 || cfg.version == 2'd1);
      sat = 1'b0;
      if (!first_seen) begin
         first_seen = 1'b1;
         return;
      end
      if (paired) begin
         if (!have_half) begin
            held_ticks = ticks;
            have_half = 1'b1;
            return;
         end
         delta = 64'(held_ticks) + 64'(ticks);
         have_half = 1'b0;
      end else begin
         have_half = 1'b0;
         delta = 64'(ticks);
      end
      prec = (cfg.precision == 8'd0) ? 64'd1 : 64'(cfg.precision);
      len = (delta * 64'(cfg.freq) / prec + 64'd500000) / 64'd1000000;
      if (len <= 64'd2040) begin
         push_word(32'((len + 64'd4) / 64'd8), tpte_pkg::CNT_BYTE, 1'b0);
      end else if (cfg.version == tpte_pkg::VER_0) begin
         cap = 64'(MAX_PAUSE_BYTES_V0_TB) * 64'd2040;
         if (len > cap) begin
            len = cap;
            sat = 1'b1;
         end
         while (len > 0) begin
            push_word(32'd0, tpte_pkg::CNT_BYTE, sat);
            len = (len > 64'd2040) ? len - 64'd2040 : 64'd0;
         end
      end else begin
         v2 = (cfg.version != 2'd1);
         cap = 64'(v2 ? MAX_PAUSE_WORDS_TB - 1 : MAX_PAUSE_WORDS_TB) * 64'hffffff;
         if (len > cap) begin
            len = cap;
            sat = 1'b1;
         end
         if (v2 && len > 64'hffffff) begin
            parts = len / 64'hffffff + ((len % 64'hffffff) != 0 ? 64'd1 : 64'd0);
            if (parts[0] == 1'b0) begin
               push_word(tpte_pkg::WORD_HALF, tpte_pkg::CNT_WORD, sat);
               push_word(tpte_pkg::WORD_HALF, tpte_pkg::CNT_WORD, sat);
               len -= 64'h00aaaaaa;
            end else if ((len % 64'hffffff) < 64'h7fffff) begin
               push_word(tpte_pkg::WORD_BIG, tpte_pkg::CNT_WORD, sat);
               len -= 64'h7fffff;
            end
         end
         while (len > 64'hffffff) begin
            push_word(tpte_pkg::WORD_FULL, tpte_pkg::CNT_WORD, sat);
            len -= 64'hffffff;
         end
         if (len > 0) push_word({len[23:0], 8'h00}, tpte_pkg::CNT_WORD, sat);
      end
      if (tap_queue.size() > before_n) tap_queue[$].last = 1'b1;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      tap_out_type t;
      if (reset) begin
         cfg.version   = 2'd1;
         cfg.freq      = 21'd985248;
         cfg.precision = 8'd1;
         first_seen    = 1'b0;
         have_half     = 1'b0;
         held_ticks    = 32'd0;
         tap_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tpte_pkg::CSR_VERSION:   cfg.version = csr_data[1:0];
               tpte_pkg::CSR_FREQ:      cfg.freq = csr_data[20:0];
               tpte_pkg::CSR_PRECISION: cfg.precision = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) encode_halfwave(req_halfwave_ticks);
         if (rsp_valid && rsp_ready) begin
            if (tap_queue.size() == 0) begin
               report_mismatch("unexpected word", rsp_data_word, 32'd0);
            end else begin
               t = tap_queue.pop_front();
               if (rsp_data_word !== t.word)
                  report_mismatch("data_word", rsp_data_word, t.word);
               if (rsp_byte_count !== t.cnt)
                  report_mismatch("byte_count", 32'(rsp_byte_count), 32'(t.cnt));
               if (rsp_last !== t.last)
                  report_mismatch("last", 32'(rsp_last), 32'(t.last));
               if (rsp_saturated !== t.sat)
                  report_mismatch("saturated", 32'(rsp_saturated), 32'(t.sat));
            end
         end
      end
   end

endmodule

/* dv/tb_tape_pulse_to_tap_encoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tape_pulse_to_tap_encoder
// Drives half-wave durations through several format versions and clock
// settings with random gaps and stalls; the checker compares every tap word.
// ----------------------------------------------------------------------------
module tb_tape_pulse_to_tap_encoder;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_halfwave_ticks;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_data_word;
   logic [2:0]  rsp_byte_count;
   logic        rsp_last;
   logic        rsp_saturated;
   int          fail_count;
   int          pending_words;
   int          cycle_count;
   logic        quiet_tail;
   logic        hold_off;

   localparam int CYCLE_LIMIT = 5000000;

   tape_pulse_to_tap_encoder u_top (.*);

   tpte_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // response side: random stall bursts, one long hold-off
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (!reset) @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            rsp_ready = 1'b0;
            repeat (600) @(negedge clock);
            hold_off = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_ready = 1'b0;
            n = $urandom_range(1, 16);
            repeat (n) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
            n = $urandom_range(1, 24);
            repeat (n) @(negedge clock);
         end
      end
   end

   task automatic send_ticks(input logic [31:0] v);
      int n;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 16);
         repeat (n) @(negedge clock);
      end
      req_valid = 1'b1;
      req_halfwave_ticks = v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain;
      while (pending_words != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic set_mode(input logic [1:0] ver, input logic [31:0] f,
                           input logic [31:0] p);
      drain();
      write_reg(tpte_pkg::CSR_VERSION, 32'(ver));
      write_reg(tpte_pkg::CSR_FREQ, f);
      write_reg(tpte_pkg::CSR_PRECISION, p);
   endtask

   // mostly short data pulses, some pauses, occasional full-range values
   function automatic logic [31:0] pick_ticks();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return $urandom_range(2000, 200000);
         2:       return $urandom_range(0, 3);
         default: return $urandom_range(100, 2200);
      endcase
   endfunction

   initial begin
      int k;
      cycle_count = 0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = tpte_pkg::CSR_VERSION;
      csr_data = '0;
      req_valid = 1'b0;
      req_halfwave_ticks = '0;
      quiet_tail = 1'b0;
      hold_off = 1'b0;
      repeat (3) @(negedge clock);
      reset = 1'b0;

      // directed, reset settings version 1
      send_ticks(32'd500);
      send_ticks(32'd0);
      send_ticks(32'd0);
      send_ticks(32'hffffffff);
      send_ticks(32'hffffffff);
      send_ticks(32'd1000);
      send_ticks(32'd1070);
      send_ticks(32'd1500);
      // version 2 with a held half pending, pauses around part boundaries
      set_mode(2'd2, 32'd1000000, 32'd1);
      send_ticks(32'h00ffffff);
      send_ticks(32'h01fffffe);
      send_ticks(32'h02fffffd);
      send_ticks(32'h01000100);
      send_ticks(32'hffffffff);
      send_ticks(32'd2040);
      send_ticks(32'd2041);
      // version 0 with zero precision and extreme clock
      set_mode(2'd0, 32'h001fffff, 32'd0);
      send_ticks(32'd2000);
      send_ticks(32'd3000);
      send_ticks(32'hffffffff);
      send_ticks(32'h80000000);
      // version three, fast timer
      set_mode(2'd3, 32'd2000000, 32'd255);
      send_ticks(32'hffffffff);
      send_ticks(32'd70000);

      // pressure: stall the response side while requests keep coming
      set_mode(2'd1, 32'd985248, 32'd1);
      hold_off = 1'b1;
      for (k = 0; k < 30; k++) send_ticks(pick_ticks());

      for (k = 0; k < 340; k++) begin
         if (k % 60 == 59)
            set_mode(2'($urandom_range(0, 3)), $urandom_range(1, 2000000),
                     $urandom_range(0, 255));
         if (k > 300) quiet_tail = 1'b1;
         send_ticks(pick_ticks());
      end
      drain();
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
